// File: rtl/core/cpd_pkg.sv
// Shared types and constants for the calibrated presence detector.
// Used by cpd_window, calibrated_presence_detector and the testbench; depends on nothing.
package cpd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 13;
  localparam int ACCUM_W  = 17;

  localparam logic [ACCUM_W-1:0]  ACCUM_MAX = '1;
  localparam logic [SAMPLE_W-1:0] LEVEL_MAX = '1;

  localparam int WINDOW_DEF     = 8;
  localparam int FIRST_END_DEF  = 40;
  localparam int SECOND_END_DEF = 72;
  localparam int BLOCK_LEN_DEF  = 32;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // One beat from the averaging front end to the calibration pipeline.
  typedef struct packed {
    logic                restart;
    logic [SAMPLE_W-1:0] average;
  } cpd_avg_t;

endpackage

// File: rtl/core/cpd_window.sv
// Moving-average front end: sample ring memory, running sum and divide by WINDOW.
// Depends on cpd_pkg.
module cpd_window
  import cpd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                operation,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                avg_valid,
  input  logic                avg_ready,
  output cpd_avg_t            avg_beat
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_W + SLOT_W;
  localparam int SH     = SUM_W + SLOT_W;
  localparam int RC_W   = SUM_W + 2;
  localparam int PROD_W = SUM_W + RC_W;
  localparam logic [63:0] RC_FULL =
    ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RC_W-1:0]   RECIP     = RC_W'(RC_FULL);
  localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'(((1 << SAMPLE_W) - 1) * WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [SAMPLE_W-1:0] win_mem [WINDOW];
  logic [WINDOW-1:0]   win_vld;
  logic [SLOT_W-1:0]   write_slot;
  logic [SUM_W-1:0]    window_sum;
  logic [SUM_W-1:0]    sum_next;

  logic                r_valid;
  logic                r_restart;
  logic [SAMPLE_W-1:0] r_sample;
  logic [SAMPLE_W-1:0] r_old;
  logic                r_old_vld;
  logic [SLOT_W-1:0]   r_slot;

  logic                s_valid;
  logic                s_restart;
  logic [SUM_W-1:0]    s_sum;

  logic                v_valid;
  cpd_avg_t            v_beat;

  logic                r_rdy;
  logic                s_rdy;
  logic                v_rdy;
  logic                item_fire;
  logic                r_move;
  logic                r_write;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   quo;

  assign v_rdy      = !v_valid || avg_ready;
  assign s_rdy      = !s_valid || v_rdy;
  assign r_rdy      = !r_valid || s_rdy;
  assign item_ready = r_rdy;
  assign item_fire  = item_valid && r_rdy;
  assign r_move     = r_valid && s_rdy;
  assign r_write    = r_move && !r_restart;

  // A slot never written since reset counts as zero.
  assign sum_next = window_sum - SUM_W'(r_old_vld ? r_old : '0) + SUM_W'(r_sample);

  // Division by WINDOW as a multiply by a rounded-up reciprocal; exact for
  // every sum below 2**SUM_W.
  assign prod = s_sum * RECIP;
  assign quo  = prod >> SH;

  // The slot is read when the beat is accepted and written one stage later.
  // Two consecutive samples always use different slots, so the write in
  // flight never targets the slot being read.
  always_ff @(posedge clk) begin
    if (r_write) begin
      win_mem[r_slot] <= r_sample;
    end
    if (item_fire) begin
      r_old     <= win_mem[write_slot];
      r_old_vld <= win_vld[write_slot];
      r_sample  <= sample;
      r_restart <= (operation == OP_RESTART);
      r_slot    <= write_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= '0;
    end else if (r_write) begin
      win_vld[r_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid    <= 1'b0;
      s_valid    <= 1'b0;
      v_valid    <= 1'b0;
      write_slot <= '0;
      window_sum <= '0;
    end else begin
      if (r_rdy) begin
        r_valid <= item_valid;
      end
      if (s_rdy) begin
        s_valid <= r_valid;
      end
      if (v_rdy) begin
        v_valid <= s_valid;
      end
      if (item_fire && operation == OP_SAMPLE) begin
        write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      end
      if (r_write) begin
        window_sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_move) begin
      s_restart <= r_restart;
      s_sum     <= sum_next;
    end
    if (s_valid && v_rdy) begin
      v_beat.restart <= s_restart;
      v_beat.average <= quo[SAMPLE_W-1:0];
    end
  end

  assign avg_valid = v_valid;
  assign avg_beat  = v_beat;

  a_slot_distinct: assert property (@(posedge clk) disable iff (rst)
    (r_write && item_fire && operation == OP_SAMPLE) |-> (r_slot != write_slot))
    else $error("window write and read hit the same slot");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    window_sum <= SUM_MAX)
    else $error("running sum exceeds a full window of maximum samples");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= LAST_SLOT)
    else $error("write slot beyond the window");

endmodule

// File: rtl/core/calibrated_presence_detector.sv
// Top level of the calibrated presence detector: calibration counter, levels and decision.
// Depends on cpd_pkg and cpd_window.
//
// Input beats (item_valid/item_ready) carry an operation and a 12-bit sample.
// A sample beat produces exactly one result beat (result_valid/result_ready)
// with present, the window average and the calibrating flag. A restart beat
// clears the calibration counter in order with the samples around it and
// produces no result.
// The block takes one beat per cycle while the receiver is ready. The ring
// memory is read at the accepting edge; then come one register each for the
// running sum, the reciprocal multiply, the calibration counter, the level
// mean multiply and the level update, two for the threshold and one for
// the output.
// Every stage holds its beat while the next one is full, so a stalled
// receiver fills the pipeline first and only then drops item_ready.
// Reset empties the pipeline and clears the window, running sum, counter,
// accumulator and both levels; there is no clearing pass, so the block
// takes beats in the cycle after reset is released.
module calibrated_presence_detector
  import cpd_pkg::*;
#(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int FIRST_END  = FIRST_END_DEF,
  parameter int SECOND_END = SECOND_END_DEF,
  parameter int BLOCK_LEN  = BLOCK_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                operation,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                result_valid,
  input  logic                result_ready,
  output logic                present,
  output logic [SAMPLE_W-1:0] average,
  output logic                calibrating
);

  localparam int CNT_TOP_AB = (FIRST_END > SECOND_END + 1) ? FIRST_END : SECOND_END + 1;
  localparam int CNT_TOP    = (WINDOW > CNT_TOP_AB) ? WINDOW : CNT_TOP_AB;
  localparam int CNT_W      = $clog2(CNT_TOP + 1);
  localparam logic [CNT_W-1:0] FIRST_C  = CNT_W'(FIRST_END);
  localparam logic [CNT_W-1:0] SECOND_C = CNT_W'(SECOND_END);
  localparam logic [CNT_W-1:0] WINDOW_C = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0] STOP_C   = CNT_W'(SECOND_END + 1);

  localparam int ASUM_W = ACCUM_W + 1;
  localparam int NUM_W  = ACCUM_W + 2;
  localparam int QW     = NUM_W - 1;
  localparam int DIV    = 2 * BLOCK_LEN;
  localparam int DIV_L  = $clog2(DIV);
  localparam int M_SH   = NUM_W + DIV_L;
  localparam int M_RC_W = NUM_W + 2;
  localparam int MP_W   = NUM_W + M_RC_W;
  localparam logic [63:0] M_RC_FULL = ((64'd1 << M_SH) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [M_RC_W-1:0] M_RECIP = M_RC_W'(M_RC_FULL);
  localparam logic [NUM_W-1:0]  BL_C    = NUM_W'(BLOCK_LEN);
  localparam logic [QW-1:0]     LVL_SAT = QW'(LEVEL_MAX);
  localparam int THR_W  = LEVEL_W + 1;

  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_A    = 2'd1;
  localparam logic [1:0] SEL_B    = 2'd2;

  logic     avg_valid;
  logic     avg_ready;
  cpd_avg_t avg_beat;

  cpd_window #(
    .WINDOW(WINDOW)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .operation (operation),
    .sample    (sample),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg_beat  (avg_beat)
  );

  // Calibration state.
  logic [CNT_W-1:0]   cal_count;
  logic [CNT_W-1:0]   count_next;
  logic [ACCUM_W-1:0] cal_accum;
  logic [ACCUM_W-1:0] accum_next;
  logic [ASUM_W-1:0]  acc_sum;
  logic [ACCUM_W-1:0] acc_sat;
  logic [1:0]         sel;

  logic signed [LEVEL_W-1:0] level_a;
  logic signed [LEVEL_W-1:0] level_b;

  // Pipeline stages after the front end.
  logic                c_valid;
  logic [SAMPLE_W-1:0] c_avg;
  logic                c_cal;
  logic [1:0]          c_sel;
  logic [ACCUM_W-1:0]  c_acc;

  logic                m_valid;
  logic [SAMPLE_W-1:0] m_avg;
  logic                m_cal;
  logic [1:0]          m_sel;
  logic [QW-1:0]       m_quo;

  logic                      l_valid;
  logic [SAMPLE_W-1:0]       l_avg;
  logic                      l_cal;
  logic signed [LEVEL_W-1:0] l_a;
  logic signed [LEVEL_W-1:0] l_b;

  logic                      g_valid;
  logic [SAMPLE_W-1:0]       g_avg;
  logic                      g_cal;
  logic                      g_dir;
  logic signed [LEVEL_W-1:0] g_b;
  logic [LEVEL_W-1:0]        g_mag;

  logic                    t_valid;
  logic [SAMPLE_W-1:0]     t_avg;
  logic                    t_cal;
  logic                    t_dir;
  logic signed [THR_W-1:0] t_thr;

  logic c_rdy;
  logic m_rdy;
  logic l_rdy;
  logic g_rdy;
  logic t_rdy;
  logic o_rdy;
  logic av_fire;

  logic [NUM_W-1:0]          m_num;
  logic [MP_W-1:0]           m_prod;
  logic [MP_W-1:0]           m_shift;
  logic [SAMPLE_W-1:0]       mean12;
  logic signed [LEVEL_W-1:0] mean_lv;
  logic signed [LEVEL_W-1:0] la_set;
  logic signed [LEVEL_W-1:0] lb_set;
  logic signed [LEVEL_W-1:0] lb_fix;
  logic [THR_W-1:0]          d_ab;
  logic [THR_W-1:0]          d_ba;
  logic [LEVEL_W-1:0]        gap;
  logic [THR_W-1:0]          b_ext;
  logic [THR_W-1:0]          gap_ext;
  logic signed [THR_W-1:0]   avg_s;
  logic                      pres;

  assign o_rdy     = !result_valid || result_ready;
  assign t_rdy     = !t_valid || o_rdy;
  assign g_rdy     = !g_valid || t_rdy;
  assign l_rdy     = !l_valid || g_rdy;
  assign m_rdy     = !m_valid || l_rdy;
  assign c_rdy     = !c_valid || m_rdy;
  assign avg_ready = c_rdy;
  assign av_fire   = avg_valid && c_rdy;

  // Calibration counter: accumulate averages after the first full window and
  // close a block at each phase end.
  always_comb begin
    acc_sum = {1'b0, cal_accum} + ASUM_W'(avg_beat.average);
    acc_sat = acc_sum[ACCUM_W] ? ACCUM_MAX : acc_sum[ACCUM_W-1:0];
    priority if (cal_count == FIRST_C) begin
      accum_next = '0;
      sel        = SEL_A;
    end else if (cal_count == SECOND_C) begin
      accum_next = '0;
      sel        = SEL_B;
    end else if (cal_count > WINDOW_C && cal_count < SECOND_C) begin
      accum_next = acc_sat;
      sel        = SEL_NONE;
    end else begin
      accum_next = cal_accum;
      sel        = SEL_NONE;
    end
    count_next = (cal_count <= SECOND_C) ? cal_count + 1'b1 : cal_count;
  end

  // Rounded block mean, (2*acc + BLOCK_LEN) / (2*BLOCK_LEN), by reciprocal.
  assign m_num   = NUM_W'({c_acc, 1'b0}) + BL_C;
  assign m_prod  = m_num * M_RECIP;
  assign m_shift = m_prod >> M_SH;

  // Level update; equal levels are pulled apart by lowering level_b.
  always_comb begin
    mean12  = (m_quo > LVL_SAT) ? LEVEL_MAX : m_quo[SAMPLE_W-1:0];
    mean_lv = {1'b0, mean12};
    la_set  = (m_sel == SEL_A) ? mean_lv : level_a;
    lb_set  = (m_sel == SEL_B) ? mean_lv : level_b;
    lb_fix  = (lb_set == la_set) ? la_set - LEVEL_W'(1) : lb_set;
  end

  assign d_ab    = {l_a[LEVEL_W-1], l_a} - {l_b[LEVEL_W-1], l_b};
  assign d_ba    = {l_b[LEVEL_W-1], l_b} - {l_a[LEVEL_W-1], l_a};
  assign gap     = LEVEL_W'((THR_W'(g_mag) + THR_W'(1)) >> 1);
  assign b_ext   = {g_b[LEVEL_W-1], g_b};
  assign gap_ext = {1'b0, gap};
  assign avg_s   = {2'b00, t_avg};
  assign pres    = t_dir ? (avg_s >= t_thr) : (avg_s <= t_thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_count    <= '0;
      cal_accum    <= '0;
      level_a      <= '0;
      level_b      <= '0;
      c_valid      <= 1'b0;
      m_valid      <= 1'b0;
      l_valid      <= 1'b0;
      g_valid      <= 1'b0;
      t_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (av_fire) begin
        if (avg_beat.restart) begin
          cal_count <= '0;
        end else begin
          cal_count <= count_next;
          cal_accum <= accum_next;
        end
      end
      if (m_valid && l_rdy) begin
        level_a <= la_set;
        level_b <= lb_fix;
      end
      if (c_rdy) begin
        c_valid <= avg_valid && !avg_beat.restart;
      end
      if (m_rdy) begin
        m_valid <= c_valid;
      end
      if (l_rdy) begin
        l_valid <= m_valid;
      end
      if (g_rdy) begin
        g_valid <= l_valid;
      end
      if (t_rdy) begin
        t_valid <= g_valid;
      end
      if (o_rdy) begin
        result_valid <= t_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (av_fire && !avg_beat.restart) begin
      c_avg <= avg_beat.average;
      c_cal <= (count_next <= SECOND_C);
      c_sel <= sel;
      c_acc <= acc_sat;
    end
    if (c_valid && m_rdy) begin
      m_avg <= c_avg;
      m_cal <= c_cal;
      m_sel <= c_sel;
      m_quo <= m_shift[QW-1:0];
    end
    if (m_valid && l_rdy) begin
      l_avg <= m_avg;
      l_cal <= m_cal;
      l_a   <= la_set;
      l_b   <= lb_fix;
    end
    if (l_valid && g_rdy) begin
      g_avg <= l_avg;
      g_cal <= l_cal;
      g_dir <= (l_b < l_a);
      g_b   <= l_b;
      g_mag <= (l_b < l_a) ? d_ab[LEVEL_W-1:0] : d_ba[LEVEL_W-1:0];
    end
    if (g_valid && t_rdy) begin
      t_avg <= g_avg;
      t_cal <= g_cal;
      t_dir <= g_dir;
      t_thr <= g_dir ? b_ext + gap_ext : b_ext - gap_ext;
    end
    if (t_valid && o_rdy) begin
      present     <= pres;
      average     <= t_avg;
      calibrating <= t_cal;
    end
  end

  a_levels_apart: assert property (@(posedge clk) disable iff (rst)
    l_valid |-> (l_a != l_b))
    else $error("levels equal after the update stage");

  a_count_stops: assert property (@(posedge clk) disable iff (rst)
    cal_count <= STOP_C)
    else $error("calibration counter ran past its stop value");

  a_gap_nonzero: assert property (@(posedge clk) disable iff (rst)
    g_valid |-> (g_mag != '0))
    else $error("zero distance between levels reached the threshold stage");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for calibrated_presence_detector: sends sample and restart beats with random
// gaps and stalls, predicts averages, calibrated levels and presence, and checks each result.
// Depends on cpd_pkg and the calibrated_presence_detector RTL.
module testbench;
  import cpd_pkg::*;

  typedef struct packed {
    logic                present;
    logic [SAMPLE_W-1:0] average;
    logic                calibrating;
  } detection_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic                operation = OP_SAMPLE;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic                present;
  logic [SAMPLE_W-1:0] average;
  logic                calibrating;

  bit         idle_on;
  int         stall_left;
  int         fail_count;
  detection_t detection_q[$];

  // Predicted state of the detector.
  logic [SAMPLE_W-1:0]       ring_buf [WINDOW_DEF];
  logic [14:0]               ring_sum;
  logic [2:0]                ring_slot;
  logic [6:0]                cal_cnt;
  logic [ACCUM_W-1:0]        cal_acc;
  logic signed [LEVEL_W-1:0] lvl_a;
  logic signed [LEVEL_W-1:0] lvl_b;

  calibrated_presence_detector u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operation    (operation),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .present      (present),
    .average      (average),
    .calibrating  (calibrating)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [ACCUM_W-1:0] accum_plus(input logic [SAMPLE_W-1:0] avg);
    int s;
    s = int'(cal_acc) + int'(avg);
    return (s > int'(ACCUM_MAX)) ? ACCUM_MAX : ACCUM_W'(s);
  endfunction

  // Rounded mean of one calibration block, rounding halves up.
  function automatic logic signed [LEVEL_W-1:0] block_level();
    int m;
    m = (2 * int'(cal_acc) + BLOCK_LEN_DEF) / (2 * BLOCK_LEN_DEF);
    if (m > int'(LEVEL_MAX)) m = int'(LEVEL_MAX);
    return LEVEL_W'(m);
  endfunction

  function automatic logic [SAMPLE_W-1:0] near(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  task automatic predict_detection(input logic op, input logic [SAMPLE_W-1:0] smp);
    logic [SAMPLE_W-1:0] avg;
    int gap;
    int lb;
    detection_t d;
    if (op == OP_RESTART) begin
      cal_cnt = '0;
    end else begin
      ring_sum = ring_sum - ring_buf[ring_slot] + smp;
      ring_buf[ring_slot] = smp;
      ring_slot = 3'((ring_slot + 1) % WINDOW_DEF);
      avg = SAMPLE_W'(ring_sum / WINDOW_DEF);
      if (cal_cnt == FIRST_END_DEF) begin
        cal_acc = accum_plus(avg);
        lvl_a = block_level();
        cal_acc = '0;
      end else if (cal_cnt == SECOND_END_DEF) begin
        cal_acc = accum_plus(avg);
        lvl_b = block_level();
        cal_acc = '0;
      end else if (cal_cnt > WINDOW_DEF && cal_cnt < SECOND_END_DEF) begin
        cal_acc = accum_plus(avg);
      end
      if (cal_cnt <= SECOND_END_DEF) cal_cnt = cal_cnt + 1'b1;
      // Equal levels are pulled apart for good, not only for this decision.
      if (lvl_b == lvl_a) lvl_b = lvl_a - 1;
      gap = int'(lvl_b) - int'(lvl_a);
      if (gap < 0) gap = -gap;
      gap = (gap + 1) / 2;
      if (gap == 0) gap = 1;
      lb = int'(lvl_b);
      d.present = (lvl_b < lvl_a) ? (int'(avg) >= lb + gap) : (int'(avg) <= lb - gap);
      d.average = avg;
      d.calibrating = (cal_cnt <= SECOND_END_DEF);
      detection_q.push_back(d);
    end
  endtask

  task automatic send_beat(input logic op, input logic [SAMPLE_W-1:0] smp);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= op;
    sample     <= smp;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_detection(op, smp);
  endtask

  task automatic report_mismatch(input string what, input detection_t want,
                                 input detection_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected present=%0b average=%0d calibrating=%0b, got %0b %0d %0b",
               $realtime, what, want.present, want.average, want.calibrating,
               got.present, got.average, got.calibrating);
  endtask

  // Receiver side: ready drops in bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 16);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    detection_t got;
    detection_t want;
    if (!rst && result_valid && result_ready) begin
      got = {present, average, calibrating};
      if (detection_q.size() == 0) begin
        want = '0;
        report_mismatch("unexpected result", want, got);
      end else begin
        want = detection_q.pop_front();
        if (got.present !== want.present || got.average !== want.average ||
            got.calibrating !== want.calibrating)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  // Extremes of the sample, restarts back to back, and the equal-level state after reset.
  task automatic test_directed();
    send_beat(OP_SAMPLE, '1);
    send_beat(OP_SAMPLE, '1);
    send_beat(OP_SAMPLE, '0);
    send_beat(OP_SAMPLE, '0);
    send_beat(OP_SAMPLE, 12'h555);
    send_beat(OP_SAMPLE, 12'hAAA);
    send_beat(OP_RESTART, '1);
    send_beat(OP_RESTART, '0);
    repeat (4) send_beat(OP_SAMPLE, '1);
    repeat (4) send_beat(OP_SAMPLE, '0);
    send_beat(OP_RESTART, 12'hAAA);
    send_beat(OP_SAMPLE, 12'd1);
    send_beat(OP_SAMPLE, 12'd4094);
    send_beat(OP_SAMPLE, 12'd2048);
  endtask

  // A flat input feeds the same value to both calibration blocks.
  task automatic test_flat_calibration();
    int v;
    case ($urandom_range(0, 2))
      0:       v = 0;
      1:       v = 4095;
      default: v = $urandom_range(0, 4095);
    endcase
    send_beat(OP_RESTART, SAMPLE_W'($urandom));
    repeat (SECOND_END_DEF + 1) send_beat(OP_SAMPLE, SAMPLE_W'(v));
    repeat (12) send_beat(OP_SAMPLE, near(v, 3));
  endtask

  // Full calibrations with two randomly drawn levels, sometimes cut short by a restart.
  task automatic test_calibration_runs(input int runs);
    int a, b, spread, cut;
    bit broken;
    for (int r = 0; r < runs; r++) begin
      a = $urandom_range(0, 4095);
      case ($urandom_range(0, 2))
        0:       b = $urandom_range(0, 4095);
        1:       b = a + $urandom_range(1, 40);
        default: b = a - int'($urandom_range(1, 40));
      endcase
      if (b < 0) b = 0;
      if (b > 4095) b = 4095;
      spread = $urandom_range(0, 48);
      broken = ($urandom_range(0, 3) == 0);
      cut = $urandom_range(1, SECOND_END_DEF - 2);
      send_beat(OP_RESTART, SAMPLE_W'($urandom));
      for (int i = 0; i <= SECOND_END_DEF; i++) begin
        if (broken && i == cut) send_beat(OP_RESTART, SAMPLE_W'($urandom));
        send_beat(OP_SAMPLE, (i <= FIRST_END_DEF) ? near(a, spread) : near(b, spread));
      end
      repeat ($urandom_range(12, 20)) begin
        case ($urandom_range(0, 3))
          0:       send_beat(OP_SAMPLE, near(a, spread));
          1:       send_beat(OP_SAMPLE, near(b, spread));
          2:       send_beat(OP_SAMPLE, near((a + b) / 2, 4));
          default: send_beat(OP_SAMPLE, SAMPLE_W'($urandom));
        endcase
      end
    end
  endtask

  task automatic test_random_noise();
    idle_on = 1'b0;
    for (int i = 0; i < 60; i++) begin
      if (i == 30) idle_on = 1'b1;
      send_beat(($urandom_range(0, 3) == 0) ? OP_RESTART : OP_SAMPLE, SAMPLE_W'($urandom));
    end
  endtask

  // Back-to-back beats with no new gaps or receiver stalls started.
  task automatic test_no_idle_tail();
    idle_on = 1'b0;
    repeat (50)
      send_beat(($urandom_range(0, 9) == 0) ? OP_RESTART : OP_SAMPLE, SAMPLE_W'($urandom));
  endtask

  initial begin
    foreach (ring_buf[i]) ring_buf[i] = '0;
    ring_sum  = '0;
    ring_slot = '0;
    cal_cnt   = '0;
    cal_acc   = '0;
    lvl_a     = '0;
    lvl_b     = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    test_directed();
    test_flat_calibration();
    test_calibration_runs(4);
    test_random_noise();
    test_no_idle_tail();
    item_valid <= 1'b0;
    for (int i = 0; i < 5000 && detection_q.size() != 0; i++) @(posedge clk);
    repeat (16) @(posedge clk);
    fail_count += detection_q.size();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: calibrated_presence_detector.f
rtl/core/cpd_pkg.sv
rtl/core/cpd_window.sv
rtl/core/calibrated_presence_detector.sv
verif/testbench.sv
